// ----- hw/rtl/bsl_pkg.sv -----
// Shared types, codes and helpers for the battery SoC limit mode machine.
// No dependencies; every module of the block imports this package.
package bsl_pkg;

    // Field and bus widths
    localparam int SOC_W       = 10;
    localparam int CNT_W       = 32;
    localparam int MODE_W      = 3;
    localparam int OP_W        = 2;
    localparam int FLAG_W      = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 24;
    localparam int OUT_PAD_W   = OUT_TDATA_W - (MODE_W + SOC_W + FLAG_W + 1);

    // Mode codes
    localparam logic [MODE_W-1:0] MODE_DISABLED    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_RESTART     = 3'd1;
    localparam logic [MODE_W-1:0] MODE_DEFAULT     = 3'd2;
    localparam logic [MODE_W-1:0] MODE_ABSORPTION  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_FLOAT       = 3'd4;
    localparam logic [MODE_W-1:0] MODE_DISCHARGED  = 3'd5;
    localparam logic [MODE_W-1:0] MODE_FORCECHARGE = 3'd6;

    // Operation codes
    localparam logic [OP_W-1:0] OP_SOC   = 2'd0;
    localparam logic [OP_W-1:0] OP_TICK  = 2'd1;
    localparam logic [OP_W-1:0] OP_WRITE = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE  = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LIMIT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LIMIT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HYSTERESIS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ABS_LEVEL   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOAT_LEVEL = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_FORCE_TICKS = 3'd6;

    // Per-day flag bit positions
    localparam int FLAG_DISCH = 0;
    localparam int FLAG_ABS   = 1;
    localparam int FLAG_FLT   = 2;

    // Configuration reset values
    localparam logic [SOC_W-1:0] RST_MIN_LIMIT   = 10'd100;
    localparam logic [SOC_W-1:0] RST_MAX_LIMIT   = 10'd800;
    localparam logic [SOC_W-1:0] RST_STEP        = 10'd50;
    localparam logic [SOC_W-1:0] RST_HYSTERESIS  = 10'd30;
    localparam logic [SOC_W-1:0] RST_ABS_LEVEL   = 10'd850;
    localparam logic [SOC_W-1:0] RST_FLOAT_LEVEL = 10'd950;
    localparam logic [CNT_W-1:0] RST_FORCE_TICKS = 32'd86400;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef struct packed {
        logic [SOC_W-1:0] min_soc_limit;
        logic [SOC_W-1:0] soc_limit_max;
        logic [SOC_W-1:0] soc_step;
        logic [SOC_W-1:0] soc_hysteresis;
        logic [SOC_W-1:0] absorption_level;
        logic [SOC_W-1:0] float_level;
        logic [CNT_W-1:0] force_charge_ticks;
    } t_cfg;

    typedef struct packed {
        logic [OP_W-1:0]   opcode;
        logic [SOC_W-1:0]  soc;
        logic              soc_valid;
        logic              sustain_active;
        logic              new_day;
        logic [MODE_W-1:0] requested_mode;
    } t_item;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [SOC_W-1:0]  soc_limit_out;
        logic [FLAG_W-1:0] flags_out;
        logic              soc_ignored;
    } t_result;

    // Move the limit by one step up or down, then clamp to [min, max];
    // the lower bound wins when the bounds are inverted.
    function automatic logic [SOC_W-1:0] move_limit(
        input logic [SOC_W-1:0] lim,
        input logic [SOC_W-1:0] step,
        input logic             up,
        input logic [SOC_W-1:0] lo,
        input logic [SOC_W-1:0] hi
    );
        logic signed [SOC_W+1:0] v;
        v = up ? ($signed({2'b00, lim}) + $signed({2'b00, step}))
               : ($signed({2'b00, lim}) - $signed({2'b00, step}));
        if (v > $signed({2'b00, hi})) begin
            v = $signed({2'b00, hi});
        end
        if (v < $signed({2'b00, lo})) begin
            v = $signed({2'b00, lo});
        end
        return v[SOC_W-1:0];
    endfunction

endpackage

// ----- hw/rtl/battery_soc_limit_state_machine.sv -----
// Top level of the battery SoC limit mode machine: input register, core, result register.
// Depends on bsl_pkg, bsl_cfg and bsl_core.
//
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+------------------------------------
//  s_axis   | in        | s_axis_tvalid/tready    | tuser: opcode; tdata: item fields
//  m_axis   | out       | m_axis_tvalid/tready    | tdata: mode, limit, flags, ignored
//  cfg      | in        | i_cfg_we (no wait)      | i_cfg_idx, i_cfg_wdata
//
// One transaction per cycle sustained while the output accepts; an accepted item is held in the input
// register, is evaluated by the core and lands in the result register when the result slot is
// free, so its result is presented from the result register. A stalled result register
// holds the input register, and input ready drops only when both are full and the output
// is stalled.
// i_rst_n is synchronous, active low; no clearing pass is needed after reset.
module battery_soc_limit_state_machine (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [9:0] soc, [10] soc_valid, [11] sustain_active, [12] new_day, [15:13] requested_mode
    input  logic [bsl_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // [1:0] opcode
    input  logic [bsl_pkg::OP_W-1:0]        s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [2:0] mode, [12:3] soc_limit_out, [15:13] flags_out, [16] soc_ignored, [23:17] zero
    output logic [bsl_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                            i_cfg_we,
    input  logic [bsl_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [bsl_pkg::CFG_DATA_W-1:0]  i_cfg_wdata
);
    import bsl_pkg::*;

    t_cfg    w_cfg;
    t_item   w_in_item;
    t_result w_result;
    logic    w_adv;

    logic    r_in_valid;
    t_item   r_in_item;
    logic    r_out_valid;
    t_result r_out;

    bsl_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    // Unpack the incoming transaction
    assign w_in_item.opcode         = s_axis_tuser;
    assign w_in_item.soc            = s_axis_tdata[SOC_W-1:0];
    assign w_in_item.soc_valid      = s_axis_tdata[SOC_W];
    assign w_in_item.sustain_active = s_axis_tdata[SOC_W+1];
    assign w_in_item.new_day        = s_axis_tdata[SOC_W+2];
    assign w_in_item.requested_mode = s_axis_tdata[SOC_W+3 +: MODE_W];

    // Advance when the input register holds an item and the result slot is free
    assign w_adv         = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_adv;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_item <= w_in_item;
        end
    end

    bsl_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (w_adv),
        .i_cfg    (w_cfg),
        .i_item   (r_in_item),
        .o_result (w_result)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, r_out.soc_ignored, r_out.flags_out,
                            r_out.soc_limit_out, r_out.mode};

`ifndef SYNTHESIS
    // An evaluated transaction always lands in the result register
    a_adv_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && w_adv |=> r_out_valid)
        else $error("bsl top: advanced transaction did not reach the result register");

    // Both stages full and the output stalled: input must be held off
    a_full_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && r_out_valid && !m_axis_tready |-> !s_axis_tready)
        else $error("bsl top: input accepted while both stages are full");
`endif

endmodule

// ----- hw/rtl/bsl_cfg.sv -----
// Configuration register file of the SoC limit mode machine.
// Depends on bsl_pkg for the register indexes, reset values and t_cfg.
module bsl_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [bsl_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bsl_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output bsl_pkg::t_cfg                  o_cfg
);
    import bsl_pkg::*;

    t_cfg r_cfg;

    // Write one register per enabled cycle; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_soc_limit      <= RST_MIN_LIMIT;
            r_cfg.soc_limit_max      <= RST_MAX_LIMIT;
            r_cfg.soc_step           <= RST_STEP;
            r_cfg.soc_hysteresis     <= RST_HYSTERESIS;
            r_cfg.absorption_level   <= RST_ABS_LEVEL;
            r_cfg.float_level        <= RST_FLOAT_LEVEL;
            r_cfg.force_charge_ticks <= RST_FORCE_TICKS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MIN_LIMIT:   r_cfg.min_soc_limit      <= i_cfg_wdata[SOC_W-1:0];
                CFG_MAX_LIMIT:   r_cfg.soc_limit_max      <= i_cfg_wdata[SOC_W-1:0];
                CFG_STEP:        r_cfg.soc_step           <= i_cfg_wdata[SOC_W-1:0];
                CFG_HYSTERESIS:  r_cfg.soc_hysteresis     <= i_cfg_wdata[SOC_W-1:0];
                CFG_ABS_LEVEL:   r_cfg.absorption_level   <= i_cfg_wdata[SOC_W-1:0];
                CFG_FLOAT_LEVEL: r_cfg.float_level        <= i_cfg_wdata[SOC_W-1:0];
                CFG_FORCE_TICKS: r_cfg.force_charge_ticks <= i_cfg_wdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- hw/rtl/bsl_core.sv -----
// Mode machine state and single-pass next-state logic for one transaction.
// Depends on bsl_pkg for codes, t_cfg, t_item, t_result and move_limit.
module bsl_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  bsl_pkg::t_cfg    i_cfg,
    input  bsl_pkg::t_item   i_item,
    output bsl_pkg::t_result o_result
);
    import bsl_pkg::*;

    logic [MODE_W-1:0] r_mode,         n_mode;
    logic [SOC_W-1:0]  r_limit,        n_limit;
    logic [FLAG_W-1:0] r_flags,        n_flags;
    logic [CNT_W-1:0]  r_count,        n_count;
    logic [SOC_W-1:0]  r_last_soc,     n_last_soc;
    logic              r_last_sustain, n_last_sustain;
    logic              r_last_valid,   n_last_valid;

    logic [MODE_W-1:0] m0;
    logic [SOC_W-1:0]  l0;
    logic [SOC_W-1:0]  lc;
    logic [FLAG_W-1:0] f0;
    logic [CNT_W-1:0]  c0;
    logic [CNT_W-1:0]  c_inc;
    logic [SOC_W-1:0]  s;
    logic              u;
    logic              do_eval;
    logic              ign;
    logic              adj;
    logic [SOC_W:0]    s_plus_hyst;
    logic [SOC_W:0]    lc_plus_hyst;

    // Apply the operation, then evaluate the chosen SoC against the mode
    always_comb begin
        n_last_soc     = r_last_soc;
        n_last_sustain = r_last_sustain;
        n_last_valid   = r_last_valid;
        m0             = r_mode;
        l0             = r_limit;
        f0             = r_flags;
        c0             = r_count;
        s              = r_last_soc;
        u              = r_last_sustain;
        do_eval        = 1'b0;
        ign            = 1'b0;
        c_inc          = (r_count == CNT_MAX) ? r_count : r_count + 1'b1;

        unique case (i_item.opcode)
            OP_SOC: begin
                n_last_soc     = i_item.soc;
                n_last_sustain = i_item.sustain_active;
                n_last_valid   = i_item.soc_valid;
                s              = i_item.soc;
                u              = i_item.sustain_active;
                do_eval        = i_item.soc_valid;
                ign            = !i_item.soc_valid;
            end
            OP_TICK: begin
                if (i_item.new_day) begin
                    f0 = '0;
                end
                // Count discharged ticks; force a charge at the limit
                if (r_mode == MODE_DISCHARGED) begin
                    c0 = c_inc;
                    if (c_inc >= i_cfg.force_charge_ticks) begin
                        l0      = move_limit(r_limit, i_cfg.soc_step, 1'b1,
                                             i_cfg.min_soc_limit, i_cfg.soc_limit_max);
                        m0      = MODE_FORCECHARGE;
                        do_eval = r_last_valid;
                        ign     = !r_last_valid;
                    end
                end
            end
            OP_WRITE: begin
                m0      = (i_item.requested_mode > MODE_FORCECHARGE) ? MODE_DEFAULT
                                                                     : i_item.requested_mode;
                do_eval = r_last_valid;
                ign     = !r_last_valid;
            end
            default: ;
        endcase

        lc           = (l0 < i_cfg.min_soc_limit) ? i_cfg.min_soc_limit : l0;
        s_plus_hyst  = {1'b0, s} + {1'b0, i_cfg.soc_hysteresis};
        lc_plus_hyst = {1'b0, lc} + {1'b0, i_cfg.soc_hysteresis};
        adj          = (m0 != MODE_RESTART);

        n_mode  = m0;
        n_limit = l0;
        n_flags = f0;
        n_count = c0;

        if (do_eval) begin
            n_limit = lc;
            unique case (m0)
                MODE_DISABLED: ;
                MODE_RESTART, MODE_DEFAULT: begin
                    if (u || s < lc) begin
                        n_mode = MODE_DISCHARGED;
                        if (adj) begin
                            if (!f0[FLAG_DISCH]) begin
                                n_flags[FLAG_DISCH] = 1'b1;
                                n_limit = move_limit(lc, i_cfg.soc_step, 1'b1,
                                                     i_cfg.min_soc_limit,
                                                     i_cfg.soc_limit_max);
                            end
                            n_count = '0;
                        end
                    end else if (s >= i_cfg.float_level) begin
                        n_mode = MODE_FLOAT;
                        if (adj && !f0[FLAG_FLT]) begin
                            n_flags[FLAG_FLT] = 1'b1;
                            n_limit = move_limit(lc, i_cfg.soc_step, 1'b0,
                                                 i_cfg.min_soc_limit, i_cfg.soc_limit_max);
                        end
                    end else if (s >= i_cfg.absorption_level) begin
                        n_mode = MODE_ABSORPTION;
                        if (adj && !f0[FLAG_ABS]) begin
                            n_flags[FLAG_ABS] = 1'b1;
                            n_limit = move_limit(lc, i_cfg.soc_step, 1'b0,
                                                 i_cfg.min_soc_limit, i_cfg.soc_limit_max);
                        end
                    end else begin
                        n_mode = MODE_DEFAULT;
                    end
                end
                MODE_DISCHARGED: begin
                    if (!u && {1'b0, s} > lc_plus_hyst) begin
                        n_mode = MODE_DEFAULT;
                    end
                end
                MODE_FORCECHARGE: begin
                    if (!u && s > lc) begin
                        n_count = '0;
                        n_mode  = MODE_DISCHARGED;
                    end
                end
                MODE_ABSORPTION: begin
                    if (s >= i_cfg.float_level) begin
                        n_mode = MODE_FLOAT;
                        if (!f0[FLAG_FLT]) begin
                            n_flags[FLAG_FLT] = 1'b1;
                            n_limit = move_limit(lc, i_cfg.soc_step, 1'b0,
                                                 i_cfg.min_soc_limit, i_cfg.soc_limit_max);
                        end
                    end else if (s_plus_hyst < {1'b0, i_cfg.absorption_level}) begin
                        n_mode = MODE_DEFAULT;
                    end
                end
                MODE_FLOAT: begin
                    if (s_plus_hyst < {1'b0, i_cfg.float_level}) begin
                        n_mode = MODE_DEFAULT;
                    end
                end
                default: n_mode = MODE_DEFAULT;
            endcase
        end
    end

    // Commit the state when the transaction moves to the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= MODE_DEFAULT;
            r_limit        <= '0;
            r_flags        <= '0;
            r_count        <= '0;
            r_last_soc     <= '0;
            r_last_sustain <= 1'b0;
            r_last_valid   <= 1'b0;
        end else if (i_adv) begin
            r_mode         <= n_mode;
            r_limit        <= n_limit;
            r_flags        <= n_flags;
            r_count        <= n_count;
            r_last_soc     <= n_last_soc;
            r_last_sustain <= n_last_sustain;
            r_last_valid   <= n_last_valid;
        end
    end

    assign o_result.mode          = n_mode;
    assign o_result.soc_limit_out = n_limit;
    assign o_result.flags_out     = n_flags;
    assign o_result.soc_ignored   = ign;

`ifndef SYNTHESIS
    // State moves only with a transaction
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_adv |=> $stable(r_mode) && $stable(r_limit) && $stable(r_flags)
                   && $stable(r_count))
        else $error("bsl_core: state changed without a transaction");

    // A valid SoC update always leaves the limit at or above the minimum
    a_limit_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && i_adv && i_item.opcode == OP_SOC && i_item.soc_valid
        |=> r_limit >= $past(i_cfg.min_soc_limit))
        else $error("bsl_core: limit below minimum after SoC update");
`endif

endmodule
